[rtl/core/radial_brush_grid_update_macros.svh]
// Assertion helpers shared by the radial brush grid block.
`ifndef RADIAL_BRUSH_GRID_UPDATE_MACROS_SVH
`define RADIAL_BRUSH_GRID_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RBG_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RBG_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) else $error(msg);

`endif

[rtl/core/rbg_pkg.sv]
package rbg_pkg;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int NODE_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(NODE_COUNT);
  localparam int XW          = $clog2(GRID_WIDTH);
  localparam int YW          = $clog2(GRID_HEIGHT);

  localparam int DENS_W      = 17;
  localparam int MAT_W       = 2;
  localparam int NODE_W      = DENS_W + MAT_W;
  localparam int RADIUS_W    = 13;
  localparam int COORD_W     = 12;
  localparam int DX_W        = 15;
  localparam int D2_W        = 27;
  localparam int ROOT_W      = 30;
  localparam int T_W         = 17;
  localparam int FRAC_SHIFT  = 32;
  localparam int COUNT_W     = 13;
  localparam int CFG_IDX_W   = 2;

  localparam logic [DENS_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DIG   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARDROCK = 2'd2;

  localparam logic [MAT_W-1:0] MAT_NORMAL   = 2'd0;
  localparam logic [MAT_W-1:0] MAT_BOUNDS   = 2'd1;
  localparam logic [MAT_W-1:0] MAT_HARDROCK = 2'd2;

  function automatic logic [DENS_W-1:0] sat_q16(input logic [DENS_W-1:0] v);
    sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [ADDR_W-1:0] node_addr(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y);
    node_addr = ADDR_W'(int'(y) * GRID_WIDTH + int'(x));
  endfunction

endpackage

[rtl/core/radial_brush_grid_update.sv]
// Command-style grid engine: pulse start while busy is low, the result shows for one
// cycle with done and cannot be held off. A write passes S_WRITE, a read S_READ and
// S_READ_WAIT; a clear writes the dirty map at one node per cycle (65536 nodes), as
// does the pass after reset, busy high. A dig has a setup state, then walks the box:
// off-grid nodes pass S_VISIT and S_NEXT, grid nodes outside the circle also S_SQ and
// S_CMP, and nodes inside also the shared square root and divide unit (30 + 17 steps)
// and up to five dirty-map writes. Configuration writes are taken in every cycle.
module radial_brush_grid_update import rbg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation,
  input  logic [7:0]           node_x,
  input  logic [7:0]           node_y,
  input  logic [DENS_W-1:0]    node_density,
  input  logic [MAT_W-1:0]     node_material,
  input  logic signed [16:0]   center_x,
  input  logic signed [16:0]   center_y,
  input  logic [RADIUS_W-1:0]  radius,
  input  logic signed [17:0]   center_gain,
  input  logic signed [17:0]   edge_might,
  output logic                 done,
  output logic [DENS_W-1:0]    read_density,
  output logic [MAT_W-1:0]     read_material,
  output logic                 read_dirty,
  output logic [COUNT_W-1:0]   nodes_changed,
  output logic                 status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DENS_W-1:0]    cfg_data
);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_WRITE     = 4'd2;
  localparam logic [3:0] S_READ      = 4'd3;
  localparam logic [3:0] S_READ_WAIT = 4'd4;
  localparam logic [3:0] S_DIG_INIT  = 4'd5;
  localparam logic [3:0] S_VISIT     = 4'd6;
  localparam logic [3:0] S_SQ        = 4'd7;
  localparam logic [3:0] S_CMP       = 4'd8;
  localparam logic [3:0] S_RATIO     = 4'd9;
  localparam logic [3:0] S_LERP1     = 4'd10;
  localparam logic [3:0] S_LERP2     = 4'd11;
  localparam logic [3:0] S_SCALE     = 4'd12;
  localparam logic [3:0] S_UPDATE    = 4'd13;
  localparam logic [3:0] S_MARK      = 4'd14;
  localparam logic [3:0] S_NEXT      = 4'd15;

  logic [3:0] state;
  logic [ADDR_W-1:0] clr_addr;
  logic clr_report;

  logic [DENS_W-1:0] dig_normal;
  logic [DENS_W-1:0] dig_bounds;
  logic [DENS_W-1:0] dig_hardrock;

  // latched command
  logic [7:0]                nx_q;
  logic [7:0]                ny_q;
  logic [DENS_W-1:0]         ndens_q;
  logic [MAT_W-1:0]          nmat_q;
  logic signed [16:0]        cx_q;
  logic signed [16:0]        cy_q;
  logic [RADIUS_W-1:0]       rad_q;
  logic signed [17:0]        cm_q;
  logic signed [17:0]        em_q;

  // dig walk
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [COORD_W-1:0] x0;
  logic signed [COORD_W-1:0] x1;
  logic signed [COORD_W-1:0] y1;
  logic [2*RADIUS_W-1:0]     r2;
  logic signed [DX_W-1:0]    dx;
  logic signed [DX_W-1:0]    dy;
  logic [D2_W-1:0]           dxsq;
  logic [D2_W-1:0]           dysq;
  logic [ADDR_W-1:0]         cur_addr;
  logic [T_W-1:0]            t_q;
  logic [DENS_W-1:0]         old_dens;
  logic [MAT_W-1:0]          cur_mat;
  logic [DENS_W-1:0]         scale_q;
  logic signed [36:0]        pdiff;
  logic signed [36:0]        lerp;
  logic [34:0]               plo;
  logic signed [36:0]        phi;
  logic [COUNT_W-1:0]        count;
  logic [2:0]                mark_step;

  // combinational
  logic                      node_inside;
  logic [ADDR_W-1:0]         op_addr;
  logic signed [18:0]        rad_s;
  logic signed [18:0]        cx_s;
  logic signed [18:0]        cy_s;
  logic signed [18:0]        bx0_w;
  logic signed [18:0]        bx1_w;
  logic signed [18:0]        by0_w;
  logic signed [18:0]        by1_w;
  logic                      box_empty;
  logic                      in_grid;
  logic signed [20:0]        dxf;
  logic signed [20:0]        dyf;
  logic signed [2*DX_W-1:0]  dxsq_w;
  logic signed [2*DX_W-1:0]  dysq_w;
  logic [D2_W-1:0]           d2_w;
  logic signed [18:0]        diff_w;
  logic signed [17:0]        t_s;
  logic signed [36:0]        pdiff_w;
  logic [55:0]               prod_w;
  logic signed [23:0]        might_w;
  logic signed [23:0]        dens_w;
  logic [DENS_W-1:0]         dens_sat;
  logic signed [COORD_W-1:0] mx;
  logic signed [COORD_W-1:0] my;
  logic                      mark_in;

  logic                      ratio_start;
  logic                      ratio_done;
  logic [T_W-1:0]            ratio_t;

  logic                      node_we;
  logic [ADDR_W-1:0]         node_waddr;
  logic [NODE_W-1:0]         node_wdata;
  logic                      node_re;
  logic [ADDR_W-1:0]         node_raddr;
  logic [NODE_W-1:0]         node_rdata;
  logic                      dirty_we;
  logic [ADDR_W-1:0]         dirty_waddr;
  logic                      dirty_wdata;
  logic                      dirty_re;
  logic [ADDR_W-1:0]         dirty_rdata_addr;
  logic                      dirty_rdata;

  function automatic logic [DENS_W-1:0] scale_of(input logic [MAT_W-1:0] m,
                                                input logic [DENS_W-1:0] s_normal,
                                                input logic [DENS_W-1:0] s_bounds,
                                                input logic [DENS_W-1:0] s_hard);
    case (m)
      MAT_NORMAL:   scale_of = s_normal;
      MAT_BOUNDS:   scale_of = s_bounds;
      MAT_HARDROCK: scale_of = s_hard;
      default:      scale_of = '0;
    endcase
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    node_inside = (int'(nx_q) < GRID_WIDTH) && (int'(ny_q) < GRID_HEIGHT);
    op_addr     = node_addr(XW'(nx_q), YW'(ny_q));

    rad_s     = $signed({6'b0, rad_q});
    cx_s      = 19'(cx_q);
    cy_s      = 19'(cy_q);
    bx0_w     = -((rad_s - cx_s) >>> 8);
    bx1_w     = (cx_s + rad_s) >>> 8;
    by0_w     = -((rad_s - cy_s) >>> 8);
    by1_w     = (cy_s + rad_s) >>> 8;
    box_empty = (rad_q == '0) || (bx0_w > bx1_w) || (by0_w > by1_w);

    in_grid = (x >= 0) && (x < GRID_WIDTH) && (y >= 0) && (y < GRID_HEIGHT);
    dxf     = (21'(x) <<< 8) - 21'(cx_q);
    dyf     = (21'(y) <<< 8) - 21'(cy_q);
    dxsq_w  = dx * dx;
    dysq_w  = dy * dy;
    d2_w    = dxsq + dysq;

    diff_w  = 19'(em_q) - 19'(cm_q);
    t_s     = $signed({1'b0, t_q});
    pdiff_w = diff_w * t_s;

    // round to nearest: add half an output LSB, then floor
    prod_w   = 56'(phi <<< 18) + 56'(plo) + (56'(1) << (FRAC_SHIFT - 1));
    might_w  = $signed(prod_w[55:32]);
    dens_w   = $signed({7'b0, old_dens}) + might_w;
    if (dens_w < 0) begin
      dens_sat = '0;
    end else if (dens_w > $signed(24'(ONE_Q16))) begin
      dens_sat = ONE_Q16;
    end else begin
      dens_sat = dens_w[DENS_W-1:0];
    end

    mx = x;
    my = y;
    case (mark_step)
      3'd1:    mx = x - 12'sd1;
      3'd2:    mx = x + 12'sd1;
      3'd3:    my = y - 12'sd1;
      3'd4:    my = y + 12'sd1;
      default: ;
    endcase
    mark_in = (mx >= 0) && (mx < GRID_WIDTH) && (my >= 0) && (my < GRID_HEIGHT);

    ratio_start = (state == S_CMP) && (d2_w <= D2_W'(r2));

    node_we    = 1'b0;
    node_waddr = cur_addr;
    node_wdata = {cur_mat, dens_sat};
    node_re    = 1'b0;
    node_raddr = node_addr(XW'(x), YW'(y));
    dirty_we   = 1'b0;
    dirty_waddr = node_addr(XW'(mx), YW'(my));
    dirty_wdata = 1'b1;
    dirty_re    = 1'b0;
    dirty_rdata_addr = op_addr;
    case (state)
      S_CLEAR: begin
        dirty_we    = 1'b1;
        dirty_waddr = clr_addr;
        dirty_wdata = 1'b0;
      end
      S_WRITE: begin
        node_we    = node_inside;
        node_waddr = op_addr;
        node_wdata = {nmat_q, sat_q16(ndens_q)};
      end
      S_READ: begin
        node_re    = node_inside;
        node_raddr = op_addr;
        dirty_re   = node_inside;
      end
      S_CMP:    node_re  = ratio_start;
      S_UPDATE: node_we  = 1'b1;
      S_MARK:   dirty_we = mark_in;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_normal   <= ONE_Q16;
      dig_bounds   <= '0;
      dig_hardrock <= 17'd16384;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NORMAL:   dig_normal   <= sat_q16(cfg_data);
        CFG_BOUNDS:   dig_bounds   <= sat_q16(cfg_data);
        CFG_HARDROCK: dig_hardrock <= sat_q16(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              done          <= 1'b1;
              read_density  <= '0;
              read_material <= '0;
              read_dirty    <= 1'b0;
              nodes_changed <= '0;
              status        <= 1'b0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            nx_q    <= node_x;
            ny_q    <= node_y;
            ndens_q <= node_density;
            nmat_q  <= node_material;
            cx_q    <= center_x;
            cy_q    <= center_y;
            rad_q   <= radius;
            cm_q    <= center_gain;
            em_q    <= edge_might;
            case (operation)
              OP_WRITE: state <= S_WRITE;
              OP_READ:  state <= S_READ;
              OP_DIG:   state <= S_DIG_INIT;
              default: begin
                clr_addr   <= '0;
                clr_report <= 1'b1;
                state      <= S_CLEAR;
              end
            endcase
          end
        end
        S_WRITE: begin
          done          <= 1'b1;
          read_density  <= '0;
          read_material <= '0;
          read_dirty    <= 1'b0;
          nodes_changed <= '0;
          status        <= !node_inside;
          state         <= S_IDLE;
        end
        S_READ: begin
          if (node_inside) begin
            state <= S_READ_WAIT;
          end else begin
            done          <= 1'b1;
            read_density  <= '0;
            read_material <= '0;
            read_dirty    <= 1'b0;
            nodes_changed <= '0;
            status        <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_READ_WAIT: begin
          done          <= 1'b1;
          read_density  <= node_rdata[DENS_W-1:0];
          read_material <= node_rdata[NODE_W-1:DENS_W];
          read_dirty    <= dirty_rdata;
          nodes_changed <= '0;
          status        <= 1'b0;
          state         <= S_IDLE;
        end
        S_DIG_INIT: begin
          x     <= COORD_W'(bx0_w);
          y     <= COORD_W'(by0_w);
          x0    <= COORD_W'(bx0_w);
          x1    <= COORD_W'(bx1_w);
          y1    <= COORD_W'(by1_w);
          r2    <= rad_q * rad_q;
          count <= '0;
          if (box_empty) begin
            done          <= 1'b1;
            read_density  <= '0;
            read_material <= '0;
            read_dirty    <= 1'b0;
            nodes_changed <= '0;
            status        <= 1'b0;
            state         <= S_IDLE;
          end else begin
            state <= S_VISIT;
          end
        end
        S_VISIT: begin
          dx    <= dxf[DX_W-1:0];
          dy    <= dyf[DX_W-1:0];
          state <= in_grid ? S_SQ : S_NEXT;
        end
        S_SQ: begin
          dxsq  <= D2_W'(dxsq_w);
          dysq  <= D2_W'(dysq_w);
          state <= S_CMP;
        end
        S_CMP: begin
          cur_addr <= node_raddr;
          state    <= ratio_start ? S_RATIO : S_NEXT;
        end
        S_RATIO: begin
          if (ratio_done) begin
            t_q      <= ratio_t;
            old_dens <= node_rdata[DENS_W-1:0];
            cur_mat  <= node_rdata[NODE_W-1:DENS_W];
            state    <= S_LERP1;
          end
        end
        S_LERP1: begin
          pdiff   <= pdiff_w;
          scale_q <= scale_of(cur_mat, dig_normal, dig_bounds, dig_hardrock);
          state   <= S_LERP2;
        end
        S_LERP2: begin
          lerp  <= (37'(cm_q) <<< 16) + pdiff;
          state <= S_SCALE;
        end
        S_SCALE: begin
          // split the lerp so each product stays below 20 x 18 bits
          plo   <= lerp[17:0] * scale_q;
          phi   <= $signed(lerp[36:18]) * $signed({1'b0, scale_q});
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          count     <= count + 1'b1;
          mark_step <= '0;
          state     <= S_MARK;
        end
        S_MARK: begin
          if (mark_step == 3'd4) begin
            state <= S_NEXT;
          end else begin
            mark_step <= mark_step + 1'b1;
          end
        end
        S_NEXT: begin
          if (x != x1) begin
            x     <= x + 12'sd1;
            state <= S_VISIT;
          end else if (y != y1) begin
            x     <= x0;
            y     <= y + 12'sd1;
            state <= S_VISIT;
          end else begin
            done          <= 1'b1;
            read_density  <= '0;
            read_material <= '0;
            read_dirty    <= 1'b0;
            nodes_changed <= count;
            status        <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rbg_ratio u_ratio (
    .clk    (clk),
    .rst    (rst),
    .start  (ratio_start),
    .d2     (d2_w),
    .radius (rad_q),
    .done   (ratio_done),
    .t      (ratio_t)
  );

  rbg_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  rbg_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_dirty_ram (
    .clk   (clk),
    .we    (dirty_we),
    .waddr (dirty_waddr),
    .wdata (dirty_wdata),
    .re    (dirty_re),
    .raddr (dirty_rdata_addr),
    .rdata (dirty_rdata)
  );

`include "radial_brush_grid_update_macros.svh"

`RBG_ASSERT_IMPL(a_done_idle, done, !busy, "result shown while engine still busy")
`RBG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not start")
`RBG_ASSERT_NEXT(a_single_result, done, !done, "two results for one transaction")
`RBG_ASSERT_IMPL(a_status_clean, done && status, read_density == '0 && nodes_changed == '0, "address error with payload")

endmodule

[rtl/core/rbg_ram.sv]
module rbg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/rbg_ratio.sv]
// t = floor(sqrt(d2 * 2^32) / radius): bit-serial square root, then restoring divide.
module rbg_ratio import rbg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [D2_W-1:0]     d2,
  input  logic [RADIUS_W-1:0] radius,
  output logic                done,
  output logic [T_W-1:0]      t
);

  localparam int REM_W  = ROOT_W + 4;
  localparam int OPND_W = 2 * ROOT_W;
  localparam int DREM_W = ROOT_W - T_W;
  localparam int STEP_W = $clog2(ROOT_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQRT = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]          phase;
  logic [STEP_W-1:0]   step;
  logic [OPND_W-1:0]   opnd;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root;
  logic [RADIUS_W-1:0] rdiv;
  logic [DREM_W-1:0]   drem;
  logic [T_W-1:0]      quo;

  logic [REM_W-1:0]    rem_s;
  logic [REM_W-1:0]    trial;
  logic                sq_take;
  logic [DREM_W:0]     drem_s;
  logic                div_take;
  logic [T_W-1:0]      quo_next;

  always_comb begin
    rem_s    = {rem[REM_W-3:0], opnd[OPND_W-1 -: 2]};
    trial    = REM_W'({root, 2'b01});
    sq_take  = rem_s >= trial;
    drem_s   = {drem, root[T_W-1]};
    div_take = drem_s >= {1'b0, rdiv};
    quo_next = {quo[T_W-2:0], div_take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            opnd  <= {{(OPND_W - D2_W - FRAC_SHIFT){1'b0}}, d2, {FRAC_SHIFT{1'b0}}};
            rem   <= '0;
            root  <= '0;
            rdiv  <= radius;
            step  <= '0;
            phase <= PH_SQRT;
          end
        end
        PH_SQRT: begin
          opnd <= opnd << 2;
          if (sq_take) begin
            rem  <= rem_s - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_s;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (step == STEP_W'(ROOT_W - 1)) begin
            step  <= '0;
            phase <= PH_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end
        PH_DIV: begin
          if (step == '0) begin
            // seed with the high part of the root, shift the rest in one bit a step
            drem <= root[ROOT_W-1:T_W];
            quo  <= '0;
            step <= step + 1'b1;
          end else begin
            root <= root << 1;
            drem <= div_take ? DREM_W'(drem_s - {1'b0, rdiv}) : drem_s[DREM_W-1:0];
            quo  <= quo_next;
            if (step == STEP_W'(T_W)) begin
              t     <= (quo_next > ONE_Q16) ? ONE_Q16 : quo_next;
              done  <= 1'b1;
              phase <= PH_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

[sim/radial_brush_grid_update_tb.sv]
`timescale 1ns / 1ps

module radial_brush_grid_update_tb;
  import rbg_pkg::*;

  localparam logic [MAT_W-1:0] MAT_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int REGION_SPAN = 12;
  localparam int FAR_BASE = GRID_WIDTH - REGION_SPAN;

  typedef struct {
    logic [1:0]             op;
    logic [7:0]             nx;
    logic [7:0]             ny;
    logic [DENS_W-1:0]      dens;
    logic [MAT_W-1:0]       mat;
    logic signed [16:0]     cx;
    logic signed [16:0]     cy;
    logic [RADIUS_W-1:0]    rad;
    logic signed [17:0]     cm;
    logic signed [17:0]     em;
  } brush_cmd_t;

  typedef struct {
    logic [DENS_W-1:0]  dens;
    logic [MAT_W-1:0]   mat;
    logic               dirty;
    logic [COUNT_W-1:0] count;
    logic               status;
  } grid_reply_t;

  class grid_scoreboard;
    bit [DENS_W-1:0] dens_mem [NODE_COUNT];
    bit [MAT_W-1:0]  mat_mem [NODE_COUNT];
    bit              written [NODE_COUNT];
    bit              dirty [NODE_COUNT];
    longint          dig_scale [3];
    grid_reply_t     expected_replies [$];
    int              errors;
    int              digs;
    longint          nodes_dug;

    function new();
      dig_scale[0] = 65536;
      dig_scale[1] = 0;
      dig_scale[2] = 16384;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_scale(logic [CFG_IDX_W-1:0] idx, logic [DENS_W-1:0] v);
      longint s;
      s = (v > ONE_Q16) ? 65536 : longint'(v);
      case (idx)
        CFG_NORMAL:   dig_scale[0] = s;
        CFG_BOUNDS:   dig_scale[1] = s;
        CFG_HARDROCK: dig_scale[2] = s;
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void mark(longint x, longint y);
      if (x < 0 || y < 0 || x >= GRID_WIDTH || y >= GRID_HEIGHT) return;
      dirty[y * GRID_WIDTH + x] = 1'b1;
    endfunction

    // Walk the circle; with apply clear, only tell whether it stays on written nodes.
    function int brush_walk(brush_cmd_t c, bit apply);
      longint cx, cy, r, cm, em, x0, x1, y0, y1, dx, dy, d2, t, lerp, might, dn, sc;
      int count, idx;
      cx = longint'(c.cx);
      cy = longint'(c.cy);
      r = longint'(c.rad);
      cm = longint'(c.cm);
      em = longint'(c.em);
      count = 0;
      if (r == 0) return 0;
      x0 = -((r - cx) >>> 8);
      x1 = (cx + r) >>> 8;
      y0 = -((r - cy) >>> 8);
      y1 = (cy + r) >>> 8;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > GRID_WIDTH - 1) x1 = GRID_WIDTH - 1;
      if (y1 > GRID_HEIGHT - 1) y1 = GRID_HEIGHT - 1;
      for (longint y = y0; y <= y1; y++) begin
        for (longint x = x0; x <= x1; x++) begin
          dx = x * 256 - cx;
          dy = y * 256 - cy;
          d2 = dx * dx + dy * dy;
          if (d2 > r * r) continue;
          idx = int'(y * GRID_WIDTH + x);
          if (!apply) begin
            if (!written[idx]) return -1;
            continue;
          end
          t = longint'(root64(longint'(d2) << 32) / r);
          if (t > 65536) t = 65536;
          sc = (mat_mem[idx] == MAT_SPARE) ? 0 : dig_scale[mat_mem[idx]];
          lerp = cm * (65536 - t) + em * t;
          might = (lerp * sc + longint'(64'h8000_0000)) >>> 32;
          dn = longint'(dens_mem[idx]) + might;
          if (dn < 0) dn = 0;
          if (dn > 65536) dn = 65536;
          dens_mem[idx] = dn[DENS_W-1:0];
          count++;
          mark(x, y);
          mark(x - 1, y);
          mark(x + 1, y);
          mark(x, y - 1);
          mark(x, y + 1);
        end
      end
      return count;
    endfunction

    function void note_item(brush_cmd_t c);
      grid_reply_t e;
      int idx;
      e = '{default: '0};
      idx = int'(c.ny) * GRID_WIDTH + int'(c.nx);
      case (c.op)
        OP_WRITE: begin
          dens_mem[idx] = (c.dens > ONE_Q16) ? ONE_Q16 : c.dens;
          mat_mem[idx] = c.mat;
          written[idx] = 1'b1;
        end
        OP_READ: begin
          e.dens = dens_mem[idx];
          e.mat = mat_mem[idx];
          e.dirty = dirty[idx];
        end
        OP_DIG: begin
          e.count = COUNT_W'(brush_walk(c, 1'b1));
          digs++;
          nodes_dug += e.count;
        end
        default: foreach (dirty[i]) dirty[i] = 1'b0;
      endcase
      expected_replies.push_back(e);
    endfunction

    task check_result(grid_reply_t got);
      grid_reply_t e;
      if (expected_replies.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      e = expected_replies.pop_front();
      if (got.dens !== e.dens)
        report($sformatf("read_density %0d, want %0d", got.dens, e.dens));
      if (got.mat !== e.mat)
        report($sformatf("read_material %0d, want %0d", got.mat, e.mat));
      if (got.dirty !== e.dirty)
        report($sformatf("read_dirty %0d, want %0d", got.dirty, e.dirty));
      if (got.count !== e.count)
        report($sformatf("nodes_changed %0d, want %0d", got.count, e.count));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start, busy, done;
  logic [1:0] operation;
  logic [7:0] node_x, node_y;
  logic [DENS_W-1:0] node_density;
  logic [MAT_W-1:0] node_material;
  logic signed [16:0] center_x, center_y;
  logic [RADIUS_W-1:0] radius;
  logic signed [17:0] center_gain, edge_might;
  logic [DENS_W-1:0] read_density;
  logic [MAT_W-1:0] read_material;
  logic read_dirty;
  logic [COUNT_W-1:0] nodes_changed;
  logic status;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DENS_W-1:0] cfg_data;

  grid_scoreboard sb = new();
  int items_sent;
  int clears_left = 4;
  bit no_idle;

  always #5 clk = ~clk;

  radial_brush_grid_update i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .node_x(node_x), .node_y(node_y),
    .node_density(node_density), .node_material(node_material),
    .center_x(center_x), .center_y(center_y), .radius(radius),
    .center_gain(center_gain), .edge_might(edge_might),
    .done(done), .read_density(read_density), .read_material(read_material),
    .read_dirty(read_dirty), .nodes_changed(nodes_changed), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{read_density, read_material, read_dirty, nodes_changed, status});
  end

  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task send_cmd(brush_cmd_t c, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= c.op;
    node_x <= c.nx;
    node_y <= c.ny;
    node_density <= c.dens;
    node_material <= c.mat;
    center_x <= c.cx;
    center_y <= c.cy;
    radius <= c.rad;
    center_gain <= c.cm;
    edge_might <= c.em;
    do @(posedge clk); while (busy);
    sb.note_item(c);
    items_sent++;
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_scale(logic [CFG_IDX_W-1:0] idx, logic [DENS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_scale(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function brush_cmd_t blank_cmd(logic [1:0] op);
    brush_cmd_t c;
    c = '{default: '0};
    c.op = op;
    c.nx = $urandom;
    c.ny = $urandom;
    c.dens = $urandom;
    c.mat = $urandom;
    c.cx = $urandom;
    c.cy = $urandom;
    c.rad = $urandom;
    c.cm = $urandom;
    c.em = $urandom;
    return c;
  endfunction

  function brush_cmd_t node_cmd(logic [1:0] op, int x, int y, int d, int m);
    brush_cmd_t c;
    c = blank_cmd(op);
    c.nx = x;
    c.ny = y;
    c.dens = d;
    c.mat = m;
    return c;
  endfunction

  function brush_cmd_t dig_cmd(int cx, int cy, int r, int cm, int em);
    brush_cmd_t c;
    c = blank_cmd(OP_DIG);
    c.cx = cx;
    c.cy = cy;
    c.rad = r;
    c.cm = cm;
    c.em = em;
    return c;
  endfunction

  function brush_cmd_t random_read();
    brush_cmd_t c;
    int base;
    c = blank_cmd(OP_READ);
    for (int k = 0; k < 50; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        base = $urandom_range(0, 1) ? FAR_BASE : 0;
        c.nx = base + $urandom_range(0, REGION_SPAN - 1);
        c.ny = base + $urandom_range(0, REGION_SPAN - 1);
      end
      if (sb.written[int'(c.ny) * GRID_WIDTH + int'(c.nx)]) return c;
      c.nx = $urandom;
      c.ny = $urandom;
    end
    c.nx = 0;
    c.ny = 0;
    return c;
  endfunction

  function brush_cmd_t random_dig();
    brush_cmd_t c;
    int base, kind;
    c = blank_cmd(OP_DIG);
    for (int k = 0; k < 30; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        base = $urandom_range(0, 1) ? FAR_BASE : 0;
        c.cx = base * 256 + $urandom_range(0, REGION_SPAN * 256) - 512;
        c.cy = base * 256 + $urandom_range(0, REGION_SPAN * 256) - 512;
        c.rad = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2047)
                                               : $urandom_range(1, 768);
      end else begin
        c.cx = $urandom;
        c.cy = $urandom;
        c.rad = $urandom;
      end
      if (sb.brush_walk(c, 1'b0) >= 0) return c;
    end
    // fall back to a circle that misses the grid
    c.cx = -65536 + $urandom_range(0, 1000);
    return c;
  endfunction

  task random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        send_cmd(blank_cmd(OP_WRITE), pick_gap());
      else if (r < 55)
        send_cmd(random_read(), pick_gap());
      else if (r == 99 && clears_left > 0) begin
        clears_left--;
        send_cmd(blank_cmd(OP_CLEAR), pick_gap());
      end else
        send_cmd(random_dig(), pick_gap());
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    operation <= OP_WRITE;
    node_x <= '0;
    node_y <= '0;
    node_density <= '0;
    node_material <= '0;
    center_x <= '0;
    center_y <= '0;
    radius <= '0;
    center_gain <= '0;
    edge_might <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NORMAL;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // populate two corner patches so every read and dig lands on written nodes
    for (int y = 0; y < REGION_SPAN; y++)
      for (int x = 0; x < REGION_SPAN; x++) begin
        send_cmd(node_cmd(OP_WRITE, x, y, $urandom_range(0, 131071),
                          $urandom_range(0, 3)), 0);
        send_cmd(node_cmd(OP_WRITE, FAR_BASE + x, FAR_BASE + y,
                          $urandom_range(0, 131071), $urandom_range(0, 3)), 0);
      end

    send_cmd(node_cmd(OP_WRITE, 0, 0, 131071, MAT_SPARE), 1);
    send_cmd(node_cmd(OP_WRITE, 255, 255, 0, MAT_BOUNDS), 0);
    send_cmd(node_cmd(OP_WRITE, 1, 0, 65536, MAT_HARDROCK), 0);
    send_cmd(node_cmd(OP_WRITE, 0, 1, 40000, MAT_NORMAL), 0);
    send_cmd(node_cmd(OP_READ, 0, 0, 0, 0), 0);
    send_cmd(node_cmd(OP_READ, 255, 255, 0, 0), 2);
    send_cmd(node_cmd(OP_READ, 1, 0, 0, 0), 0);
    send_cmd(dig_cmd(128, 128, 0, 131071, 131071), 0);
    send_cmd(dig_cmd(0, 0, 3071, 131071, -131072), 0);
    send_cmd(dig_cmd(65535, 65535 - 256, 3000, -131072, 131071), 3);
    send_cmd(dig_cmd(-65536, -65536, 8191, 131071, 131071), 0);
    send_cmd(dig_cmd(65535, 65535, 3071, -131072, -131072), 0);
    send_cmd(dig_cmd(-300, 200, 600, -65536, 65536), 0);
    send_cmd(dig_cmd(512, 512, 256, 0, 0), 0);
    send_cmd(node_cmd(OP_READ, 0, 1, 0, 0), 0);
    send_cmd(node_cmd(OP_READ, 2, 2, 0, 0), 0);
    send_cmd(node_cmd(OP_CLEAR, 0, 0, 0, 0), 0);
    send_cmd(node_cmd(OP_READ, 0, 0, 0, 0), 0);
    send_cmd(node_cmd(OP_READ, 255, 255, 0, 0), 0);
    drain();

    write_scale(CFG_NORMAL, 131071);
    write_scale(CFG_BOUNDS, 65536);
    write_scale(CFG_HARDROCK, 0);
    write_scale(CFG_SPARE, 12345);
    random_phase(70);
    drain();

    write_scale(CFG_NORMAL, 0);
    write_scale(CFG_BOUNDS, $urandom_range(0, 131071));
    write_scale(CFG_HARDROCK, 65536);
    no_idle = 1'b1;
    random_phase(70);
    no_idle = 1'b0;
    drain();

    write_scale(CFG_NORMAL, $urandom_range(0, 65536));
    write_scale(CFG_BOUNDS, $urandom_range(0, 65536));
    write_scale(CFG_HARDROCK, $urandom_range(0, 131071));
    random_phase(65);
    drain();

    write_scale(CFG_NORMAL, 65536);
    write_scale(CFG_BOUNDS, 0);
    write_scale(CFG_HARDROCK, 16384);
    random_phase(65);
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d transactions, %0d digs touching %0d nodes in total.",
             items_sent, sb.digs, sb.nodes_dug);
    $display("Config swept through zero, full, saturating and reset scales.");
    if (sb.errors == 0 && sb.expected_replies.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d results outstanding", sb.expected_replies.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[radial_brush_grid_update.f]
+incdir+rtl/core
rtl/core/rbg_pkg.sv
rtl/core/rbg_ram.sv
rtl/core/rbg_ratio.sv
rtl/core/radial_brush_grid_update.sv
sim/radial_brush_grid_update_tb.sv
